// ----- sv/lsfc_pkg.sv -----
// ----------------------------------------------------------------------------
// LIN slave frame checker package
// Shared item types, status codes, identifier parity and checksum functions.
// ----------------------------------------------------------------------------
package lsfc_pkg;

	// Number of data bytes in one frame.
	localparam int DATA_BYTES = 8;

	// Byte position codes for the frame sequencer.
	localparam int POS_W = 4;
	localparam logic [POS_W-1:0] POS_IDLE       = POS_W'(0);
	localparam logic [POS_W-1:0] POS_SYNC       = POS_W'(1);
	localparam logic [POS_W-1:0] POS_FIRST_DATA = POS_W'(2);
	localparam logic [POS_W-1:0] POS_CHECKSUM   = POS_W'(DATA_BYTES + 2);

	// Highest slave identifier that a configuration write may set.
	localparam logic [5:0] MAX_SLAVE_ID = 6'd59;

	// Frame verdict codes.
	typedef logic [1:0] frame_status_t;
	localparam frame_status_t ST_OK       = 2'd0;
	localparam frame_status_t ST_PARITY   = 2'd1;
	localparam frame_status_t ST_MISMATCH = 2'd2;
	localparam frame_status_t ST_CHECKSUM = 2'd3;

	// One received byte.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} rx_item_t;

	// One frame verdict.
	typedef struct packed {
		frame_status_t          frame_status;
		logic [5:0]             frame_id;
		logic [8*DATA_BYTES-1:0] payload;
	} res_item_t;

	// Checks the two parity bits of a protected identifier.
	function automatic logic parity_ok(input logic [7:0] pid);
		logic p0;
		logic p1;
		p0 = pid[0] ^ pid[1] ^ pid[2] ^ pid[4];
		p1 = ~(pid[1] ^ pid[3] ^ pid[4] ^ pid[5]);
		return (pid[6] == p0) && (pid[7] == p1);
	endfunction

	// Adds one byte to the sum with end-around carry.
	function automatic logic [7:0] add_carry(input logic [7:0] sum, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, sum} + {1'b0, b};
		return s[7:0] + {7'd0, s[8]};
	endfunction

endpackage

// ----- sv/lin_slave_frame_checker_unit.sv -----
// ----------------------------------------------------------------------------
// LIN slave frame checker
// Checks identifier parity, slave identifier and classic checksum of LIN
// frames received one byte at a time, and reports one verdict per frame.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while no stall holds it
// back. A byte is captured in an input register, from which the frame
// sequencer updates its state; at the checksum byte the verdict is loaded
// into the result register in the same cycle as that sequencer update. The
// rate is set by the update of the running checksum and frame position.
// Bytes are only held back while a verdict waits in the result register and
// the next checksum byte needs it.
// The slave identifier is written through the configuration port; the user
// must write it only while no frame is in progress, which the block does not
// enforce. Writes above 59 are ignored.
module lin_slave_frame_checker_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_wdata,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  lsfc_pkg::rx_item_t rx_item,
	output logic               res_valid,
	input  logic               res_stall,
	output lsfc_pkg::res_item_t res_item
);
	import lsfc_pkg::*;

	localparam int PAYLOAD_W = 8 * DATA_BYTES;
	localparam int IDX_W     = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

	logic [5:0]           slave_id_q;
	logic                 valid_s1;
	rx_item_t             item_s1;
	logic [POS_W-1:0]     pos_q;
	logic [7:0]           sum_q;
	logic [7:0]           pid_q;
	logic [PAYLOAD_W-1:0] incoming_q;
	logic [PAYLOAD_W-1:0] accepted_q;
	logic                 res_valid_q;
	res_item_t            res_item_q;

	logic                 is_verdict;
	logic                 advance;
	logic [POS_W-1:0]     data_off;
	logic [IDX_W-1:0]     byte_idx;
	frame_status_t        status;

	// The staged byte produces a verdict only at the checksum position.
	assign is_verdict = valid_s1 && !item_s1.frame_start && (pos_q == POS_CHECKSUM);
	assign advance    = !is_verdict || !res_valid_q || !res_stall;
	assign rx_stall   = valid_s1 && !advance;
	assign data_off   = pos_q - POS_FIRST_DATA;
	assign byte_idx   = data_off[IDX_W-1:0];

	// Verdict with parity first, then identifier, then checksum.
	always_comb begin
		if (!parity_ok(pid_q)) begin
			status = ST_PARITY;
		end else if (pid_q[5:0] != slave_id_q) begin
			status = ST_MISMATCH;
		end else if ((sum_q ^ 8'hFF) != item_s1.rx_byte) begin
			status = ST_CHECKSUM;
		end else begin
			status = ST_OK;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_id_q <= '0;
		end else if (cfg_we && cfg_wdata <= MAX_SLAVE_ID) begin
			slave_id_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			item_s1 <= rx_item;
		end
	end

	// Frame sequencer and checksum accumulation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_IDLE;
			sum_q      <= '0;
			pid_q      <= '0;
			incoming_q <= '0;
			accepted_q <= '0;
		end else if (valid_s1 && advance) begin
			if (item_s1.frame_start) begin
				pos_q      <= POS_SYNC;
				sum_q      <= '0;
				pid_q      <= '0;
				incoming_q <= '0;
			end else if (pos_q == POS_SYNC) begin
				pid_q <= item_s1.rx_byte;
				pos_q <= POS_FIRST_DATA;
			end else if (pos_q != POS_IDLE && pos_q < POS_CHECKSUM) begin
				incoming_q[8*byte_idx +: 8] <= item_s1.rx_byte;
				sum_q                       <= add_carry(sum_q, item_s1.rx_byte);
				pos_q                       <= pos_q + POS_W'(1);
			end else if (pos_q == POS_CHECKSUM) begin
				if (status == ST_OK) begin
					accepted_q <= incoming_q;
				end
				pos_q <= POS_IDLE;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (is_verdict && advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_verdict && advance) begin
			res_item_q.frame_status <= status;
			res_item_q.frame_id     <= pid_q[5:0];
			res_item_q.payload      <= (status == ST_OK) ? incoming_q : accepted_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LIN slave frame checker testbench
// Drives received bytes through the checker with random gaps and stalls on
// both channels. A directed table walks through accepted and rejected frames.
// Random frames follow, both well formed and broken, under several slave
// identifier settings. Every verdict is compared with a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
	import lsfc_pkg::*;

	localparam int HOLD_OFF_CYCLES = 120;
	localparam int SETTLE_CYCLES   = 8;
	localparam int STALL_LIMIT     = 1000;
	localparam int PHASE_BYTES     = 90;
	localparam int NUM_PHASES      = 6;

	// One row of the directed byte table.
	typedef struct {
		logic [7:0]    rx_byte;
		logic          frame_start;
		bit            typed;
		frame_status_t status;
		logic [5:0]    id;
	} byte_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_we = 1'b0;
	logic [5:0] cfg_wdata = '0;
	logic      rx_valid = 1'b0;
	logic      rx_stall;
	rx_item_t  rx_item = '0;
	logic      res_valid;
	logic      res_stall = 1'b1;
	res_item_t res_item;

	// Predicted checker state.
	logic [5:0]  cur_slave_id;
	logic [3:0]  frame_pos;
	logic [7:0]  frame_sum;
	logic [7:0]  frame_pid;
	logic [63:0] frame_data;
	logic [63:0] kept_payload;

	res_item_t pending_verdicts[$];
	res_item_t want;
	int        errors = 0;
	int        bytes_used = 0;
	int        idle_cycles = 0;
	bit        quiet = 1'b0;
	bit        hold_off_req = 1'b0;

	// Directed frames: one accepted frame of all-ones data, then a frame with a
	// bad identifier parity whose payload must repeat the accepted data.
	byte_row_t directed_rows[23] = '{
		'{8'hFF, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'h00, 1'b1, 1'b0, ST_OK, 6'd0},
		'{8'h80, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'h00, 1'b0, 1'b1, ST_OK, 6'd0},
		'{8'hFF, 1'b1, 1'b0, ST_OK, 6'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 6'd0},
		'{8'h55, 1'b0, 1'b1, ST_PARITY, 6'd0}
	};

	lin_slave_frame_checker_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_item   (rx_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Builds a protected identifier with correct parity bits.
	function automatic logic [7:0] protect_id(input logic [5:0] id);
		return {~(id[1] ^ id[3] ^ id[4] ^ id[5]), id[0] ^ id[1] ^ id[2] ^ id[4], id};
	endfunction

	// Adds a byte to the classic checksum, folding the carry back in.
	function automatic logic [7:0] sum_wrap(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > 9'd255)
			s = s - 9'd255;
		return s[7:0];
	endfunction

	// Advances the predicted state by one received byte; returns 1 with the
	// verdict when the byte closes a frame.
	function automatic bit predict_verdict(input rx_item_t item, output res_item_t v);
		logic [2:0]    k;
		frame_status_t st;
		v = '0;
		if (item.frame_start) begin
			frame_pos = POS_SYNC;
			frame_sum = '0;
			frame_pid = '0;
			frame_data = '0;
			return 1'b0;
		end
		if (frame_pos == POS_IDLE)
			return 1'b0;
		if (frame_pos == POS_SYNC) begin
			frame_pid = item.rx_byte;
			frame_pos = POS_FIRST_DATA;
			return 1'b0;
		end
		if (frame_pos < POS_CHECKSUM) begin
			k = 3'(frame_pos - POS_FIRST_DATA);
			frame_data[8*k +: 8] = item.rx_byte;
			frame_sum = sum_wrap(frame_sum, item.rx_byte);
			frame_pos = frame_pos + 4'd1;
			return 1'b0;
		end
		// Checksum byte: parity first, then identifier, then checksum.
		if (frame_pid != protect_id(frame_pid[5:0]))
			st = ST_PARITY;
		else if (frame_pid[5:0] != cur_slave_id)
			st = ST_MISMATCH;
		else if (~frame_sum != item.rx_byte)
			st = ST_CHECKSUM;
		else
			st = ST_OK;
		if (st == ST_OK)
			kept_payload = frame_data;
		v.frame_status = st;
		v.frame_id = frame_pid[5:0];
		v.payload = kept_payload;
		frame_pos = POS_IDLE;
		return 1'b1;
	endfunction

	// Offers one byte after a random gap and records its verdict, if any.
	task automatic send_byte(input logic [7:0] b, input logic start, input bit typed = 1'b0,
			input frame_status_t st = ST_OK, input logic [5:0] id = '0);
		rx_item_t  item;
		res_item_t v;
		int        gap;
		item.rx_byte = b;
		item.frame_start = start;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_item <= item;
		do @(posedge clk); while (rx_stall);
		if (start || frame_pos != POS_IDLE)
			bytes_used++;
		if (predict_verdict(item, v)) begin
			if (typed) begin
				v.frame_status = st;
				v.frame_id = id;
			end
			pending_verdicts.push_back(v);
		end
	endtask

	// Sends one random sequence: stray bytes, a truncated frame, or a whole
	// frame whose identifier and checksum are mostly right.
	task automatic send_random_seq(input bit whole);
		int         kind;
		int         mode;
		int         len;
		logic [7:0] body[10];
		logic [7:0] sum;
		kind = whole ? 99 : $urandom_range(0, 99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 4))
				send_byte(8'($urandom), 1'b0);
			return;
		end
		mode = $urandom_range(0, 9);
		if (mode < 7)
			body[0] = protect_id(cur_slave_id);
		else if (mode < 9)
			body[0] = protect_id(6'($urandom_range(0, 63)));
		else
			body[0] = 8'($urandom);
		mode = $urandom_range(0, 19);
		sum = '0;
		for (int i = 1; i <= 8; i++) begin
			body[i] = (mode == 0) ? 8'h00 : (mode == 1) ? 8'hFF : 8'($urandom);
			sum = sum_wrap(sum, body[i]);
		end
		body[9] = ($urandom_range(0, 99) < 85) ? ~sum : 8'($urandom);
		len = (kind < 18) ? $urandom_range(0, 9) : 10;
		send_byte(8'($urandom), 1'b1);
		for (int i = 0; i < len; i++)
			send_byte(body[i], 1'b0);
	endtask

	// Waits until every verdict is in, then lets the block settle.
	task automatic wait_drained();
		rx_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_slave_id(input logic [5:0] id);
		cfg_we <= 1'b1;
		cfg_wdata <= id;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (id <= MAX_SLAVE_ID)
			cur_slave_id = id;
	endtask

	// Stimulus: reset, directed table, then random phases.
	initial begin
		logic [5:0] phase_ids[NUM_PHASES];
		int         first;
		cur_slave_id = '0;
		frame_pos = POS_IDLE;
		frame_sum = '0;
		frame_pid = '0;
		frame_data = '0;
		kept_payload = '0;
		phase_ids = '{6'd59, 6'd62, 6'd0, 6'd60, 6'($urandom_range(1, 58)), 6'd63};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].rx_byte, directed_rows[i].frame_start,
				directed_rows[i].typed, directed_rows[i].status, directed_rows[i].id);

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			write_slave_id(phase_ids[p]);
			quiet = (p % 3 == 1);
			if (p == 1)
				hold_off_req = 1'b1;
			first = bytes_used;
			while (bytes_used - first < PHASE_BYTES)
				send_random_seq(1'b0);
			send_random_seq(1'b1);
		end

		wait_drained();
		if (errors == 0 && pending_verdicts.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Result side: random stalls, one long hold-off on request.
	initial begin
		int stall_cycles;
		wait (arst_n);
		forever begin
			stall_cycles = quiet ? 0 : $urandom_range(0, 4);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_cycles = HOLD_OFF_CYCLES;
			end
			if (stall_cycles != 0) begin
				res_stall <= 1'b1;
				repeat (stall_cycles) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	// Compares each accepted verdict with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_verdicts.size() == 0) begin
				$error("verdict item with none expected: %p", res_item);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (res_item.frame_status !== want.frame_status) begin
					$error("frame_status: expected %0d, got %0d",
						want.frame_status, res_item.frame_status);
					errors++;
				end
				if (res_item.frame_id !== want.frame_id) begin
					$error("frame_id: expected %0d, got %0d", want.frame_id, res_item.frame_id);
					errors++;
				end
				if (res_item.payload !== want.payload) begin
					$error("payload: expected %h, got %h", want.payload, res_item.payload);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles where neither channel moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && !rx_stall) || (res_valid && !res_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule

// ----- files.f -----
sv/lsfc_pkg.sv
sv/lin_slave_frame_checker_unit.sv
verif/tb_top.sv
